// File: src/dfmod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double fmod package
// Shared types and constants for the double-precision remainder block.
// ----------------------------------------------------------------------------
package dfmod_pkg;

    localparam int unsigned WordWidth = 64;
    localparam int unsigned ExpWidth  = 11;
    localparam int unsigned FracWidth = 52;
    localparam int unsigned MantWidth = 53;

    localparam logic [ExpWidth-1:0] ExpAll = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NORM,
        ST_DENORM,
        ST_DONE
    } state_t;

    // control from sequencer to datapath
    typedef struct packed {
        logic load;
        logic reduce;
        logic norm;
        logic denorm;
    } dp_ctrl_t;

    // status from datapath to sequencer
    typedef struct packed {
        logic early;       // result decided at unpack
        logic ex_gt_ey;    // more reduction steps left
        logic mant_top;    // hidden bit position set
        logic mant_zero;   // remainder is zero
        logic exp_pos;     // biased exponent above zero
        logic shift_done;  // subnormal shift finished
    } dp_stat_t;

endpackage

// File: src/dfmod_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double fmod sequencer
// Steps the shared datapath through reduce, normalize and subnormal shift.
// ----------------------------------------------------------------------------
module dfmod_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                out_taken,
    input  dfmod_pkg::dp_stat_t stat,
    output dfmod_pkg::dp_ctrl_t ctrl,
    output logic                busy,
    output logic                done
);
    import dfmod_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start) state_next = ST_REDUCE;
            ST_REDUCE:
                priority if (stat.early)       state_next = ST_DONE;
                else if (stat.ex_gt_ey)        state_next = ST_REDUCE;
                else if (stat.mant_zero)       state_next = ST_DONE;
                else                           state_next = ST_NORM;
            ST_NORM:
                priority if (!stat.mant_top)   state_next = ST_NORM;
                else if (stat.exp_pos)         state_next = ST_DONE;
                else                           state_next = ST_DENORM;
            ST_DENORM:
                if (stat.shift_done) state_next = ST_DONE;
            ST_DONE:
                if (out_taken) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                ctrl.load = start;
            end
            ST_REDUCE: ctrl.reduce = !stat.early;
            ST_NORM:   ctrl.norm   = !stat.mant_top;
            ST_DENORM: ctrl.denorm = !stat.shift_done;
            ST_DONE:   done = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

endmodule

// File: src/dfmod_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double fmod datapath
// Unpack, one shared compare-subtract-shift step, result packing.
// ----------------------------------------------------------------------------
module dfmod_dp
(
    input  logic                                clk,
    input  logic [dfmod_pkg::WordWidth-1:0]     x_in,
    input  logic [dfmod_pkg::WordWidth-1:0]     y_in,
    input  dfmod_pkg::dp_ctrl_t                 ctrl,
    output dfmod_pkg::dp_stat_t                 stat,
    output logic [dfmod_pkg::WordWidth-1:0]     result
);
    import dfmod_pkg::*;

    // mantissa is a full word; the shift-subtract wraps at the word width
    logic [WordWidth-1:0]   mx_reg;
    logic [MantWidth-1:0]   my_reg;
    logic [ExpWidth:0]      ex_reg;   // signed-ish via offset; see below
    logic [ExpWidth:0]      ey_reg;
    logic                   sx_reg;
    logic                   early_reg;
    logic [WordWidth-1:0]   early_val_reg;
    logic [ExpWidth:0]      dshift_reg;  // remaining right shift

    // unpack
    logic [WordWidth-2:0] ax, ay;
    logic [ExpWidth-1:0]  exx, eyy;
    logic                 special, x_nan;
    logic [WordWidth-1:0] early_val;
    logic                 is_early;

    always_comb
    begin
        ax  = x_in[WordWidth-2:0];
        ay  = y_in[WordWidth-2:0];
        exx = ax[WordWidth-2:FracWidth];
        eyy = ay[WordWidth-2:FracWidth];
        special = (eyy == ExpAll) || (ay == '0) || (exx == ExpAll);
        x_nan   = (exx == ExpAll) && (ax[FracWidth-1:0] != '0);
        is_early = 1'b1;
        priority if (special)
            early_val = {(x_in[WordWidth-1] && ax != '0 && !x_nan), {(WordWidth-1){1'b0}}};
        else if (ax < ay)
            early_val = x_in;
        else if (ax == ay)
            early_val = {x_in[WordWidth-1], {(WordWidth-1){1'b0}}};
        else
        begin
            early_val = '0;
            is_early = 1'b0;
        end
    end

    // shared compare-subtract step
    logic [WordWidth-1:0] sub_val;
    always_comb
    begin
        if (mx_reg >= {{(WordWidth-MantWidth){1'b0}}, my_reg})
            sub_val = mx_reg - {{(WordWidth-MantWidth){1'b0}}, my_reg};
        else
            sub_val = mx_reg;
    end

    // exponent of a normalizing result; ex_reg holds e + MantWidth offset
    // during normalize so it never goes negative
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sx_reg        <= x_in[WordWidth-1];
            early_reg     <= is_early;
            early_val_reg <= early_val;
            mx_reg <= {{(WordWidth-MantWidth){1'b0}}, (exx != '0), ax[FracWidth-1:0]};
            my_reg <= {(eyy != '0), ay[FracWidth-1:0]};
            ex_reg <= (exx == '0) ? (ExpWidth+1)'(1) : {1'b0, exx};
            ey_reg <= (eyy == '0) ? (ExpWidth+1)'(1) : {1'b0, eyy};
        end
        else if (ctrl.reduce)
        begin
            if (ex_reg > ey_reg)
            begin
                mx_reg <= {sub_val[WordWidth-2:0], 1'b0};
                ex_reg <= ex_reg - (ExpWidth+1)'(1);
            end
            else
            begin
                mx_reg <= sub_val;
                // start normalize with exponent ey, offset by MantWidth
                ex_reg <= ey_reg + (ExpWidth+1)'(MantWidth);
            end
        end
        else if (ctrl.norm)
        begin
            mx_reg <= {mx_reg[WordWidth-2:0], 1'b0};
            ex_reg <= ex_reg - (ExpWidth+1)'(1);
        end
        else if (ctrl.denorm)
        begin
            mx_reg     <= {1'b0, mx_reg[WordWidth-1:1]};
            dshift_reg <= dshift_reg - (ExpWidth+1)'(1);
        end
        // right shift count 1 - e = MantWidth + 2 - ex_reg, taken from
        // ex_reg before this step's decrement
        if (ctrl.norm)
            dshift_reg <= (ExpWidth+1)'(MantWidth + 2) - ex_reg;
    end

    always_comb
    begin
        stat.early      = early_reg;
        stat.ex_gt_ey   = ex_reg > ey_reg;
        stat.mant_top   = mx_reg[FracWidth];
        stat.mant_zero  = (sub_val == '0);
        stat.exp_pos    = ex_reg > (ExpWidth+1)'(MantWidth);
        stat.shift_done = (dshift_reg == '0);
    end

    logic [ExpWidth:0] e_bias;
    always_comb
    begin
        e_bias = ex_reg - (ExpWidth+1)'(MantWidth);
        priority if (early_reg)
            result = early_val_reg;
        else if (mx_reg == '0)
            result = {sx_reg, {(WordWidth-1){1'b0}}};
        else if (mx_reg[FracWidth] && ex_reg > (ExpWidth+1)'(MantWidth))
            result = {sx_reg, e_bias[ExpWidth-1:0], mx_reg[FracWidth-1:0]};
        else
            result = {sx_reg, {(WordWidth-1){1'b0}}} | mx_reg;
    end

endmodule

// File: src/double_fmod_remainder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double fmod remainder
// Truncated remainder of two IEEE-754 doubles, sign of the dividend.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: dividend_bits, divisor_bits with in_valid / in_stall.
//   Output channel: remainder_bits with out_valid / out_stall.
//   One item is in flight at a time; in_stall is high from the input
//   transfer until the result transfer and then drops while idle.
//   For special cases and |x| <= |y| the sequencer goes from reduce
//   straight to done; otherwise it runs reduce steps, then, unless the
//   remainder is zero, normalize steps and, for a subnormal result,
//   subnormal shift steps. The reduce steps use the shared
//   compare-subtract-shift step over the mantissa. The next item is
//   taken in the cycle after the result transfer at the earliest.
//   The result stays in its register while out_stall is high.
//   Reset returns the sequencer to idle; no transfer is pending after it.
//   NaN or infinite operands and a zero divisor give a zero result.
// ----------------------------------------------------------------------------
module double_fmod_remainder_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dfmod_pkg::WordWidth-1:0] dividend_bits,
    input  logic [dfmod_pkg::WordWidth-1:0] divisor_bits,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dfmod_pkg::WordWidth-1:0] remainder_bits
);
    import dfmod_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic     busy, done;

    assign in_stall  = busy;
    assign out_valid = done;

    dfmod_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && !busy),
        .out_taken (!out_stall),
        .stat      (stat),
        .ctrl      (ctrl),
        .busy      (busy),
        .done      (done)
    );

    dfmod_dp u_dp
    (
        .clk    (clk),
        .x_in   (dividend_bits),
        .y_in   (divisor_bits),
        .ctrl   (ctrl),
        .stat   (stat),
        .result (remainder_bits)
    );

endmodule

// File: src/dfmod_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double fmod checker
// Port-level checks on the transfer ordering of the remainder block.
// ----------------------------------------------------------------------------
module dfmod_sva
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] remainder_bits
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(remainder_bits))
        else $error("result dropped while stalled");

    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !out_valid)
        else $error("no work after transfer");

    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid && !in_stall)
        else $error("not idle after result transfer");
endmodule

bind double_fmod_remainder_top dfmod_sva u_chk
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .remainder_bits (remainder_bits)
);
